@@ hdl/tcre_pkg.sv @@
// shared types, codes and register-class helpers for the toy cpu register execute unit
package tcre_pkg;

   localparam int RegCount = 11;

   typedef logic [1:0]  kind_type;
   typedef logic [3:0]  reg_num_type;
   typedef logic [31:0] word_type;
   typedef logic [1:0]  status_type;

   localparam kind_type KIND_SET = 2'd0;
   localparam kind_type KIND_SUM = 2'd1;
   localparam kind_type KIND_SUB = 2'd2;
   localparam kind_type KIND_JNZ = 2'd3;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_UNKNOWN = 2'd1;
   localparam status_type ST_WIDTH   = 2'd2;

   localparam reg_num_type REG_PC = 4'd0;
   localparam reg_num_type REG_AX = 4'd1;
   localparam reg_num_type REG_DX = 4'd4;

   localparam word_type MASK_NARROW = 32'h0000_00FF;
   localparam word_type MASK_WIDE   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        en;
      reg_num_type addr;
      word_type    data;
   } wr_port_type;

   typedef struct packed {
      status_type status;
      logic       jumped;
      word_type   program_counter;
      word_type   written_value;
   } result_type;

   function automatic logic reg_known(reg_num_type r);
      return {28'd0, r} < RegCount[31:0];
   endfunction

   function automatic logic reg_narrow(reg_num_type r);
      return (r >= REG_AX) && (r <= REG_DX);
   endfunction

   function automatic word_type reg_mask(reg_num_type r);
      return reg_narrow(r) ? MASK_NARROW : MASK_WIDE;
   endfunction

endpackage

@@ hdl/tcre_req_if.sv @@
// instruction channel: valid/ready handshake with the instruction fields
interface tcre_req_if;
   import tcre_pkg::*;

   logic        valid;
   logic        ready;
   kind_type    kind;
   reg_num_type first_reg;
   reg_num_type second_reg;
   word_type    operand_value;

   modport source(output valid, output kind, output first_reg, output second_reg,
                  output operand_value, input ready);
   modport sink(input valid, input kind, input first_reg, input second_reg,
                input operand_value, output ready);
endinterface

@@ hdl/tcre_rsp_if.sv @@
// result channel: valid/ready handshake with status, jump flag, pc and written value
interface tcre_rsp_if;
   import tcre_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic       jumped;
   word_type   program_counter;
   word_type   written_value;

   modport source(output valid, output status, output jumped, output program_counter,
                  output written_value, input ready);
   modport sink(input valid, input status, input jumped, input program_counter,
                input written_value, output ready);
endinterface

@@ hdl/toy_cpu_register_execute_unit.sv @@
// top level of the toy cpu register execute unit
// Executes one instruction per transfer on an eleven-entry register file (PC, AX..DX,
// EAX..EDX, SI, DI) and returns one result per instruction. A new instruction can be
// taken every cycle while results are taken. The register file is read into registers
// at the transfer edge; the execute stage then decodes, adds or subtracts and writes
// back as its result moves on, with the write of the instruction ahead forwarded into
// the operands. The result sits in an output register; while a result waits, at most
// one more instruction is taken and then the input stalls. The register file reads as
// zero from reset on with no clearing pass.
module toy_cpu_register_execute_unit (
   input logic          clock,
   input logic          reset,
   tcre_req_if.sink     req_chan,
   tcre_rsp_if.source   rsp_chan
);
   import tcre_pkg::*;

   logic        ex_valid_ff;
   logic        ex_valid_in;
   kind_type    ex_kind_ff;
   reg_num_type ex_first_ff;
   reg_num_type ex_second_ff;
   word_type    ex_value_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  out_result_ff;
   word_type    pc_ff;

   logic        advance;
   logic        accept;
   word_type    src_value;
   word_type    dst_value;
   result_type  ex_result;
   wr_port_type alu_wr;
   wr_port_type commit_wr;

   assign advance        = ex_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !ex_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ex_valid_in  = accept || (ex_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_kind_ff   <= req_chan.kind;
         ex_first_ff  <= req_chan.first_reg;
         ex_second_ff <= req_chan.second_reg;
         ex_value_ff  <= req_chan.operand_value;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= ex_result;
      end
   end

   // mirror of register 0 for the program counter output
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (commit_wr.en && (commit_wr.addr == REG_PC)) begin
         pc_ff <= commit_wr.data;
      end
   end

   always_comb begin
      commit_wr    = alu_wr;
      commit_wr.en = alu_wr.en && advance;
   end

   tcre_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_chan.first_reg),
      .rd_addr_b (req_chan.second_reg),
      .wr        (commit_wr),
      .rd_data_a (src_value),
      .rd_data_b (dst_value)
   );

   tcre_alu u_alu (
      .kind          (ex_kind_ff),
      .first_reg     (ex_first_ff),
      .second_reg    (ex_second_ff),
      .operand_value (ex_value_ff),
      .src_value     (src_value),
      .dst_value     (dst_value),
      .pc_value      (pc_ff),
      .result        (ex_result),
      .wr            (alu_wr)
   );

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_result_ff.status;
   assign rsp_chan.jumped          = out_result_ff.jumped;
   assign rsp_chan.program_counter = out_result_ff.program_counter;
   assign rsp_chan.written_value   = out_result_ff.written_value;

endmodule

@@ hdl/tcre_regfile.sv @@
// register file memory with registered reads, reset valid bits and write forwarding
module tcre_regfile (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  tcre_pkg::reg_num_type rd_addr_a,
   input  tcre_pkg::reg_num_type rd_addr_b,
   input  tcre_pkg::wr_port_type wr,
   output tcre_pkg::word_type    rd_data_a,
   output tcre_pkg::word_type    rd_data_b
);
   import tcre_pkg::*;

   word_type            mem_ff [RegCount];
   logic [RegCount-1:0] valid_ff;
   word_type            rd_a_ff;
   word_type            rd_b_ff;
   reg_num_type         addr_a_ff;
   reg_num_type         addr_b_ff;
   logic                lw_valid_ff;
   reg_num_type         lw_addr_ff;
   word_type            lw_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en && reg_known(wr.addr)) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && reg_known(wr.addr)) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff   <= (reg_known(rd_addr_a) && valid_ff[rd_addr_a]) ? mem_ff[rd_addr_a] : '0;
         rd_b_ff   <= (reg_known(rd_addr_b) && valid_ff[rd_addr_b]) ? mem_ff[rd_addr_b] : '0;
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   // a write committed at the read edge is missed by the array read
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (wr.en) begin
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         lw_addr_ff <= wr.addr;
         lw_data_ff <= wr.data;
      end
   end

   assign rd_data_a = (lw_valid_ff && (lw_addr_ff == addr_a_ff)) ? lw_data_ff : rd_a_ff;
   assign rd_data_b = (lw_valid_ff && (lw_addr_ff == addr_b_ff)) ? lw_data_ff : rd_b_ff;

endmodule

@@ hdl/tcre_alu.sv @@
// instruction decode, add/subtract, jump test and result formation
module tcre_alu (
   input  tcre_pkg::kind_type    kind,
   input  tcre_pkg::reg_num_type first_reg,
   input  tcre_pkg::reg_num_type second_reg,
   input  tcre_pkg::word_type    operand_value,
   input  tcre_pkg::word_type    src_value,
   input  tcre_pkg::word_type    dst_value,
   input  tcre_pkg::word_type    pc_value,
   output tcre_pkg::result_type  result,
   output tcre_pkg::wr_port_type wr
);
   import tcre_pkg::*;

   word_type sum_value;
   word_type diff_value;

   assign sum_value  = dst_value + src_value;
   assign diff_value = dst_value - src_value;

   always_comb begin
      wr            = '0;
      result.status = ST_DONE;
      result.jumped = 1'b0;
      unique case (kind)
         KIND_SET: begin
            if (!reg_known(first_reg)) begin
               result.status = ST_UNKNOWN;
            end else begin
               wr.en   = 1'b1;
               wr.addr = first_reg;
               wr.data = operand_value & reg_mask(first_reg);
            end
         end
         KIND_SUM, KIND_SUB: begin
            if (!reg_known(first_reg) || !reg_known(second_reg)) begin
               result.status = ST_UNKNOWN;
            end else if (reg_narrow(first_reg) != reg_narrow(second_reg)) begin
               result.status = ST_WIDTH;
            end else begin
               wr.en   = 1'b1;
               wr.addr = second_reg;
               wr.data = ((kind == KIND_SUM) ? sum_value : diff_value) & reg_mask(second_reg);
            end
         end
         KIND_JNZ: begin
            if (!reg_known(first_reg)) begin
               result.status = ST_UNKNOWN;
            end else if ((src_value & reg_mask(first_reg)) != '0) begin
               wr.en         = 1'b1;
               wr.addr       = REG_PC;
               wr.data       = operand_value;
               result.jumped = 1'b1;
            end
         end
         default: begin
            result.status = ST_DONE;
         end
      endcase
      result.written_value   = wr.en ? wr.data : '0;
      result.program_counter = (wr.en && (wr.addr == REG_PC)) ? wr.data : pc_value;
   end

endmodule

@@ tb/tb_top.sv @@
// testbench for the toy cpu register execute unit: directed and random instructions
`timescale 1ns / 1ps

module tb_top;
   import tcre_pkg::*;

   // register numbers the package leaves unnamed
   localparam reg_num_type RN_BX  = 4'd2;
   localparam reg_num_type RN_CX  = 4'd3;
   localparam reg_num_type RN_EAX = 4'd5;
   localparam reg_num_type RN_EBX = 4'd6;
   localparam reg_num_type RN_ECX = 4'd7;
   localparam reg_num_type RN_EDX = 4'd8;
   localparam reg_num_type RN_SI  = 4'd9;
   localparam reg_num_type RN_DI  = 4'd10;
   localparam reg_num_type RN_UNK_LO = 4'd11;
   localparam reg_num_type RN_UNK_HI = 4'd15;

   logic clock;
   logic reset;
   int   idle_pct;
   int   error_count;

   word_type   arch_regs [RegCount];
   result_type expected_results [$];

   tcre_req_if req_chan ();
   tcre_rsp_if rsp_chan ();

   toy_cpu_register_execute_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400us;
      $display("toy_cpu_register_execute_unit: mismatch");
      $finish;
   end

   function automatic logic known_reg(reg_num_type r);
      return r < RN_UNK_LO;
   endfunction

   function automatic logic narrow_reg(reg_num_type r);
      return r >= REG_AX && r <= REG_DX;
   endfunction

   function automatic word_type width_mask(reg_num_type r);
      return narrow_reg(r) ? MASK_NARROW : MASK_WIDE;
   endfunction

   // updates the architectural copy and returns the result the unit must give
   function automatic result_type exec_predict(kind_type k, reg_num_type a, reg_num_type b,
                                               word_type v);
      result_type r;
      word_type   acc;
      r = '0;
      r.status = ST_DONE;
      case (k)
         KIND_SET: begin
            if (!known_reg(a)) begin
               r.status = ST_UNKNOWN;
            end else begin
               arch_regs[a] = v & width_mask(a);
               r.written_value = arch_regs[a];
            end
         end
         KIND_SUM, KIND_SUB: begin
            if (!known_reg(a) || !known_reg(b)) begin
               r.status = ST_UNKNOWN;
            end else if (narrow_reg(a) != narrow_reg(b)) begin
               r.status = ST_WIDTH;
            end else begin
               acc = (k == KIND_SUM) ? arch_regs[b] + arch_regs[a] : arch_regs[b] - arch_regs[a];
               arch_regs[b] = acc & width_mask(b);
               r.written_value = arch_regs[b];
            end
         end
         default: begin
            if (!known_reg(a)) begin
               r.status = ST_UNKNOWN;
            end else if ((arch_regs[a] & width_mask(a)) != '0) begin
               arch_regs[REG_PC] = v;
               r.jumped = 1'b1;
               r.written_value = v;
            end
         end
      endcase
      r.program_counter = arch_regs[REG_PC];
      return r;
   endfunction

   // called at a rising edge; returns at the edge of the transfer
   task automatic issue_instr(kind_type k, reg_num_type a, reg_num_type b, word_type v);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= k;
      req_chan.first_reg     <= a;
      req_chan.second_reg    <= b;
      req_chan.operand_value <= v;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (taken !== 1'b1);
      expected_results.push_back(exec_predict(k, a, b, v));
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= idle_pct);
   end

   // outputs are stable at the falling edge, so a transfer seen here lands at the next rise
   always @(negedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no instruction outstanding");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.jumped !== want.jumped) begin
               $error("jumped: expected %0d, got %0d", want.jumped, rsp_chan.jumped);
               error_count++;
            end
            if (rsp_chan.program_counter !== want.program_counter) begin
               $error("program_counter: expected %h, got %h", want.program_counter,
                      rsp_chan.program_counter);
               error_count++;
            end
            if (rsp_chan.written_value !== want.written_value) begin
               $error("written_value: expected %h, got %h", want.written_value,
                      rsp_chan.written_value);
               error_count++;
            end
         end
      end
   end

   task automatic test_set_all();
      issue_instr(KIND_SET, REG_PC, REG_PC, 32'hFFFF_FFFF);
      issue_instr(KIND_SET, REG_AX, RN_UNK_HI, 32'hFFFF_FFFF);
      issue_instr(KIND_SET, RN_BX, REG_PC, 32'h0000_0080);
      issue_instr(KIND_SET, RN_EAX, REG_PC, 32'h8000_0000);
      issue_instr(KIND_SET, RN_DI, REG_PC, 32'h0000_0001);
      issue_instr(KIND_SET, RN_SI, REG_PC, 32'h7FFF_FFFF);
      issue_instr(KIND_SET, RN_UNK_LO, REG_PC, 32'h5555_5555);
      issue_instr(KIND_SET, RN_UNK_HI, REG_PC, 32'hAAAA_AAAA);
   endtask

   task automatic test_arith_cases();
      // same register twice: doubling wraps at 8 bits, subtraction clears
      issue_instr(KIND_SUM, REG_AX, REG_AX, '0);
      issue_instr(KIND_SUM, RN_EAX, RN_DI, '0);
      issue_instr(KIND_SUB, RN_DI, RN_DI, '0);
      issue_instr(KIND_SUM, REG_AX, RN_EAX, '0);
      issue_instr(KIND_SUB, RN_EBX, RN_UNK_LO + 4'd1, '0);
      issue_instr(KIND_SUM, RN_UNK_HI - 4'd2, RN_ECX, '0);
      issue_instr(KIND_SUB, RN_BX, RN_CX, '0);
      issue_instr(KIND_SUM, RN_SI, REG_PC, '0);
   endtask

   task automatic test_jump_cases();
      issue_instr(KIND_JNZ, RN_EAX, REG_PC, 32'h0000_1234);
      issue_instr(KIND_JNZ, RN_CX, RN_UNK_HI, 32'hFFFF_FFFF);
      issue_instr(KIND_JNZ, REG_DX, REG_PC, 32'hDEAD_BEEF);
      issue_instr(KIND_JNZ, RN_UNK_HI - 4'd1, REG_PC, 32'h0000_0042);
      issue_instr(KIND_JNZ, REG_PC, RN_EDX, 32'h0000_0000);
   endtask

   task automatic test_random_mix(int count);
      kind_type    k;
      reg_num_type a;
      reg_num_type b;
      word_type    v;
      for (int i = 0; i < count; i++) begin
         // busy stretch with no idling on either side in the middle of the run
         idle_pct = (i >= count / 3 && i < 2 * count / 3) ? 0 : 32;
         k = kind_type'($urandom_range(3));
         a = ($urandom_range(9) == 0) ? reg_num_type'($urandom_range(RN_UNK_HI, RN_UNK_LO))
                                      : reg_num_type'($urandom_range(RN_DI, REG_PC));
         if ($urandom_range(1) == 0 && known_reg(a)) begin
            b = narrow_reg(a) ? reg_num_type'($urandom_range(REG_DX, REG_AX))
                              : reg_num_type'($urandom_range(RN_DI, RN_EAX));
            if ($urandom_range(4) == 0 && !narrow_reg(a)) b = REG_PC;
         end else begin
            b = reg_num_type'($urandom_range(RN_UNK_HI, REG_PC));
         end
         case ($urandom_range(3))
            0: v = $urandom_range(255);
            1: v = $urandom_range(1) ? MASK_WIDE : '0;
            default: v = $urandom;
         endcase
         issue_instr(k, a, b, v);
      end
   endtask

   initial begin
      reset = 1'b1;
      idle_pct = 32;
      error_count = 0;
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_SET;
      req_chan.first_reg = REG_PC;
      req_chan.second_reg = REG_PC;
      req_chan.operand_value = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_set_all();
      test_arith_cases();
      test_jump_cases();
      test_random_mix(430);

      req_chan.valid <= 1'b0;
      idle_pct = 32;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("toy_cpu_register_execute_unit: match");
      end else begin
         $display("toy_cpu_register_execute_unit: mismatch");
      end
      $finish;
   end

endmodule
